[rtl/core/bpd_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpd_pkg
// types, codes and the keyword name rom shared by the detokenizer modules
// ---------------------------------------------------------------------------
package bpd_pkg;

   localparam int KwCount   = 128;
   localparam int NameBytes = 8;
   localparam int PowCount  = 5;

   typedef enum logic [2:0] {
      PH_CR, PH_HI, PH_LO, PH_LEN, PH_BODY, PH_PACK
   } phase_type;

   typedef enum logic [1:0] {
      JOB_NONE, JOB_CHAR, JOB_KW, JOB_DEC
   } kind_type;

   localparam logic [2:0] ST_RUN     = 3'd0;
   localparam logic [2:0] ST_END     = 3'd1;
   localparam logic [2:0] ST_NO_CR   = 3'd2;
   localparam logic [2:0] ST_PAST    = 3'd3;
   localparam logic [2:0] ST_OVERRUN = 3'd4;

   localparam logic REG_PAGE_HIGH = 1'b0;
   localparam logic REG_RAM_LIMIT = 1'b1;

   localparam logic [7:0] CH_CR      = 8'h0d;
   localparam logic [7:0] CH_LF      = 8'h0a;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_QUOTE   = 8'h22;
   localparam logic [7:0] TOK_LINENO = 8'h8d;
   localparam logic [7:0] TOK_DATA   = 8'hdc;
   localparam logic [7:0] TOK_REM    = 8'hf4;

   // one result group handed from the parser to the emitter
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  chr;
      logic [15:0] value;
      logic        pad;
      logic        nl;
      logic [2:0]  status;
   } job_type;

   // names right-justified, zero padded
   localparam logic [8*NameBytes-1:0] KW_NAME [KwCount] = '{
      "AND", "DIV", "EOR", "MOD", "OR", "ERROR", "LINE", "OFF",
      "STEP", "SPC", "TAB(", "ELSE", "THEN", "", "OPENIN", "PTR",
      "PAGE", "TIME", "LOMEM", "HIMEM", "ABS", "ACS", "ADVAL", "ASC",
      "ASN", "ATN", "BGET", "COS", "COUNT", "DEG", "ERL", "ERR",
      "EVAL", "EXP", "EXT", "FALSE", "FN", "GET", "INKEY", "INSTR(",
      "INT", "LEN", "LN", "LOG", "NOT", "OPENUP", "OPENOUT", "PI",
      "POINT(", "POS", "RAD", "RND", "SGN", "SIN", "SQR", "TAN",
      "TO", "TRUE", "USR", "VAL", "VPOS", "CHR$", "GET$", "INKEY$",
      "LEFT$(", "MID$(", "RIGHT$(", "STR$", "STRING$(", "EOF", "AUTO", "DELETE",
      "LOAD", "LIST", "NEW", "OLD", "RENUMBER", "SAVE", "", "PTR",
      "PAGE", "TIME", "LOMEM", "HIMEM", "SOUND", "BPUT", "CALL", "CHAIN",
      "CLEAR", "CLOSE", "CLG", "CLS", "DATA", "DEF", "DIM", "DRAW",
      "END", "ENDPROC", "ENVELOPE", "FOR", "GOSUB", "GOTO", "GCOL", "IF",
      "INPUT", "LET", "LOCAL", "MODE", "MOVE", "NEXT", "ON", "VDU",
      "PLOT", "PRINT", "PROC", "READ", "REM", "REPEAT", "REPORT", "RESTORE",
      "RETURN", "RUN", "STOP", "COLOUR", "TRACE", "UNTIL", "WIDTH", "OSCLI"
   };

   // k * 10^p for digit extraction
   localparam logic [16:0] DEC_STEP [PowCount][10] = '{
      '{17'd0, 17'd1, 17'd2, 17'd3, 17'd4, 17'd5, 17'd6, 17'd7, 17'd8, 17'd9},
      '{17'd0, 17'd10, 17'd20, 17'd30, 17'd40, 17'd50, 17'd60, 17'd70, 17'd80,
        17'd90},
      '{17'd0, 17'd100, 17'd200, 17'd300, 17'd400, 17'd500, 17'd600, 17'd700,
        17'd800, 17'd900},
      '{17'd0, 17'd1000, 17'd2000, 17'd3000, 17'd4000, 17'd5000, 17'd6000,
        17'd7000, 17'd8000, 17'd9000},
      '{17'd0, 17'd10000, 17'd20000, 17'd30000, 17'd40000, 17'd50000,
        17'd60000, 17'd70000, 17'd80000, 17'd90000}
   };

endpackage

[rtl/core/bpd_emit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpd_emit
// holds one result group and sends its characters one transfer per cycle unless rsp_stall holds it
// ---------------------------------------------------------------------------
module bpd_emit (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  bpd_pkg::job_type job,
   output logic             take,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_text_char,
   output logic             rsp_char_valid,
   output logic [2:0]       rsp_status,
   output logic             rsp_last
);
   import bpd_pkg::*;

   logic                     busy_ff, busy_in;
   kind_type                 kind_ff, kind_in;
   logic [2:0]               cnt_ff, cnt_in;
   logic [15:0]              rem_ff, rem_in;
   logic [8*NameBytes-1:0]   name_ff, name_in;
   logic [7:0]               chr_ff, chr_in;
   logic                     pad_ff, pad_in;
   logic                     nl_ff, nl_in;
   logic                     started_ff, started_in;
   logic [2:0]               status_ff, status_in;

   logic [8*NameBytes-1:0]   new_name;
   logic [3:0]               new_len;
   logic [3:0]               digit;
   logic                     advance;
   logic                     cnt_zero;

   always_comb begin
      new_name = KW_NAME[job.chr[6:0]];
      new_len  = '0;
      for (int i = 0; i < NameBytes; i++) begin
         if (new_name[8*i +: 8] != 8'h00) new_len = 4'(i + 1);
      end
   end

   // digit at the current power
   always_comb begin
      digit = '0;
      for (int k = 1; k < 10; k++) begin
         if ({1'b0, rem_ff} >= DEC_STEP[cnt_ff][k]) digit = digit + 4'd1;
      end
   end

   assign cnt_zero = (cnt_ff == 3'd0);

   always_comb begin
      rsp_text_char  = 8'h00;
      rsp_char_valid = 1'b1;
      rsp_last       = 1'b0;
      unique case (kind_ff)
         JOB_NONE: begin
            rsp_char_valid = nl_ff;
            rsp_text_char  = nl_ff ? CH_LF : 8'h00;
            rsp_last       = 1'b1;
         end
         JOB_CHAR: begin
            rsp_text_char = chr_ff;
            rsp_last      = !nl_ff;
         end
         JOB_KW: begin
            rsp_text_char = name_ff[cnt_ff*8 +: 8];
            rsp_last      = cnt_zero && !nl_ff;
         end
         JOB_DEC: begin
            if (pad_ff && !started_ff && digit == 4'd0 && !cnt_zero) begin
               rsp_text_char = CH_SPACE;
            end else begin
               rsp_text_char = CH_ZERO + {4'd0, digit};
            end
            rsp_last = cnt_zero && !nl_ff;
         end
         default: ;
      endcase
   end

   assign rsp_valid  = busy_ff;
   assign rsp_status = status_ff;
   assign advance    = busy_ff && !rsp_stall;
   assign take       = !busy_ff || (advance && rsp_last);

   always_comb begin
      busy_in    = busy_ff;
      kind_in    = kind_ff;
      cnt_in     = cnt_ff;
      rem_in     = rem_ff;
      name_in    = name_ff;
      chr_in     = chr_ff;
      pad_in     = pad_ff;
      nl_in      = nl_ff;
      started_in = started_ff;
      status_in  = status_ff;
      if (load) begin
         busy_in    = 1'b1;
         kind_in    = job.kind;
         chr_in     = job.chr;
         rem_in     = job.value;
         pad_in     = job.pad;
         nl_in      = job.nl;
         status_in  = job.status;
         name_in    = new_name;
         started_in = 1'b0;
         cnt_in     = '0;
         if (job.kind == JOB_KW) begin
            if (new_len == 4'd0) kind_in = JOB_NONE;
            else cnt_in = 3'(new_len - 4'd1);
         end else if (job.kind == JOB_DEC) begin
            priority if (job.pad || job.value >= 16'd10000) cnt_in = 3'd4;
            else if (job.value >= 16'd1000) cnt_in = 3'd3;
            else if (job.value >= 16'd100)  cnt_in = 3'd2;
            else if (job.value >= 16'd10)   cnt_in = 3'd1;
            else cnt_in = 3'd0;
         end
      end else if (advance) begin
         if (rsp_last) busy_in = 1'b0;
         unique case (kind_ff)
            JOB_CHAR: kind_in = JOB_NONE;
            JOB_KW: begin
               if (cnt_zero) kind_in = JOB_NONE;
               else cnt_in = cnt_ff - 3'd1;
            end
            JOB_DEC: begin
               rem_in     = rem_ff - DEC_STEP[cnt_ff][digit][15:0];
               started_in = started_ff || (digit != 4'd0);
               if (cnt_zero) kind_in = JOB_NONE;
               else cnt_in = cnt_ff - 3'd1;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         kind_ff <= JOB_NONE;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         kind_ff <= kind_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      name_ff    <= name_in;
      chr_ff     <= chr_in;
      pad_ff     <= pad_in;
      nl_ff      <= nl_in;
      started_ff <= started_in;
      status_ff  <= status_in;
   end

endmodule

[rtl/core/basic_program_detokenizer_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// basic_program_detokenizer_top
// tokenized basic program bytes in, plain text characters out
// ---------------------------------------------------------------------------
// one program byte per req transfer, in address order; req_begin_req restarts
// at page_high*256 with that byte. every byte gives one or more rsp transfers
// (up to nine: a keyword plus newline), the last marked by rsp_last; a byte
// that prints nothing gives a single transfer with rsp_char_valid low. the
// header/body parser updates its state in the cycle the byte is taken, so a
// byte whose group is a single transfer is followed by the next byte in the
// next cycle unless rsp_stall holds it; a longer group holds req until its
// last transfer goes, the emitter sending one character per unstalled cycle.
// csr writes are always ready and are meant for idle periods only.
module basic_program_detokenizer_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_mem_byte,
   input  logic        req_begin_req,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_text_char,
   output logic        rsp_char_valid,
   output logic [2:0]  rsp_status,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import bpd_pkg::*;

   // configuration registers
   logic [7:0]  page_high_ff;
   logic [15:0] ram_limit_ff;

   // parser state
   phase_type   phase_ff, phase_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] line_ff, line_in;
   logic [7:0]  remain_ff, remain_in;
   logic [7:0]  pb0_ff, pb0_in;
   logic [7:0]  pb1_ff, pb1_in;
   logic [1:0]  pcount_ff, pcount_in;
   logic        in_str_ff, in_str_in;
   logic        raw_ff, raw_in;
   logic [2:0]  status_ff, status_in;

   job_type     job;
   logic        take;
   logic        accept;
   logic [16:0] line_end;
   logic [15:0] packed_val;
   logic [7:0]  b;
   logic        check_end;

   assign csr_ready = 1'b1;
   assign accept    = req_valid && take;
   assign req_stall = !take;
   assign b         = req_mem_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_high_ff <= 8'd14;
         ram_limit_ff <= 16'd32764;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_PAGE_HIGH: page_high_ff <= csr_wdata[7:0];
            REG_RAM_LIMIT: ram_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // packed line number after a 0x8d token, completed by this byte
   assign packed_val = {pb0_ff[3:2], b[5:0], pb0_ff[5:4], pb1_ff[5:0]} ^ 16'h4040;

   // next parser state and the result group for the byte at the req port
   always_comb begin
      phase_in  = phase_ff;
      addr_in   = addr_ff;
      line_in   = line_ff;
      remain_in = remain_ff;
      pb0_in    = pb0_ff;
      pb1_in    = pb1_ff;
      pcount_in = pcount_ff;
      in_str_in = in_str_ff;
      raw_in    = raw_ff;
      status_in = status_ff;
      check_end = 1'b0;
      job       = '{kind: JOB_NONE, chr: b, value: line_ff, pad: 1'b1,
                    nl: 1'b0, status: ST_RUN};

      // begin clears the parse and restarts at page
      if (req_begin_req) begin
         phase_in  = PH_CR;
         line_in   = '0;
         remain_in = '0;
         pb0_in    = '0;
         pb1_in    = '0;
         pcount_in = '0;
         in_str_in = 1'b0;
         raw_in    = 1'b0;
         status_in = ST_RUN;
         addr_in   = {page_high_ff, 8'h00};
         if (addr_in >= ram_limit_ff) status_in = ST_PAST;
      end

      line_end = {1'b0, addr_in + 16'd1} + {9'd0, b};

      if (status_in == ST_RUN) begin
         unique case (phase_in)
            PH_HI: begin
               if (b[7]) status_in = ST_END;
               else begin
                  line_in  = {b, 8'h00};
                  phase_in = PH_LO;
               end
            end
            PH_LO: begin
               line_in  = {line_in[15:8], b};
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               if (line_end >= {1'b0, ram_limit_ff}) status_in = ST_PAST;
               else begin
                  job.kind  = JOB_DEC;
                  job.value = line_in;
                  remain_in = b - 8'd4;
                  phase_in  = PH_BODY;
                  check_end = 1'b1;
               end
            end
            PH_BODY: begin
               remain_in = remain_in - 8'd1;
               check_end = 1'b1;
               priority if (raw_in) job.kind = JOB_CHAR;
               else if (in_str_in) begin
                  job.kind = JOB_CHAR;
                  if (b == CH_QUOTE) in_str_in = 1'b0;
               end else if (b == TOK_LINENO) begin
                  check_end = 1'b0;
                  if (remain_in < 8'd3) status_in = ST_OVERRUN;
                  else begin
                     pcount_in = '0;
                     phase_in  = PH_PACK;
                  end
               end else if (b[7]) begin
                  job.kind = JOB_KW;
                  if (b == TOK_DATA || b == TOK_REM) raw_in = 1'b1;
               end else begin
                  job.kind = JOB_CHAR;
                  if (b == CH_QUOTE) in_str_in = 1'b1;
               end
            end
            PH_PACK: begin
               remain_in = remain_in - 8'd1;
               unique case (pcount_in)
                  2'd0: begin
                     pb0_in    = b;
                     pcount_in = 2'd1;
                  end
                  2'd1: begin
                     pb1_in    = b;
                     pcount_in = 2'd2;
                  end
                  default: begin
                     job.kind  = JOB_DEC;
                     job.value = packed_val;
                     job.pad   = 1'b0;
                     pcount_in = '0;
                     phase_in  = PH_BODY;
                     check_end = 1'b1;
                  end
               endcase
            end
            default: begin
               if (b != CH_CR) status_in = ST_NO_CR;
               else phase_in = PH_HI;
            end
         endcase
         // line body used up: newline and back to header
         if (check_end && remain_in == 8'd0) begin
            job.nl    = 1'b1;
            phase_in  = PH_CR;
            in_str_in = 1'b0;
            raw_in    = 1'b0;
         end
         addr_in = addr_in + 16'd1;
      end
      job.status = status_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_CR;
         addr_ff   <= '0;
         line_ff   <= '0;
         remain_ff <= '0;
         pb0_ff    <= '0;
         pb1_ff    <= '0;
         pcount_ff <= '0;
         in_str_ff <= 1'b0;
         raw_ff    <= 1'b0;
         status_ff <= ST_RUN;
      end else if (accept) begin
         phase_ff  <= phase_in;
         addr_ff   <= addr_in;
         line_ff   <= line_in;
         remain_ff <= remain_in;
         pb0_ff    <= pb0_in;
         pb1_ff    <= pb1_in;
         pcount_ff <= pcount_in;
         in_str_ff <= in_str_in;
         raw_ff    <= raw_in;
         status_ff <= status_in;
      end
   end

   // character emitter, doubles as the output register
   bpd_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .load           (accept),
      .job            (job),
      .take           (take),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_text_char  (rsp_text_char),
      .rsp_char_valid (rsp_char_valid),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

[rtl/core/bpd_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bpd_checker
// port level checks on the detokenizer, bound to the top level
// ---------------------------------------------------------------------------
module bpd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_text_char,
   input logic       rsp_char_valid,
   input logic       rsp_last
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_text_char))
      else $error("stalled result changed");

   // an empty result is a whole group by itself
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_char_valid |-> rsp_last && rsp_text_char == 8'h00)
      else $error("empty result not alone");

   // input waits while a result waits
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall)
      else $error("input taken while result stalled");

   // nothing pending means input is open
   a_idle_open: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while idle");

endmodule

bind basic_program_detokenizer_top bpd_checker u_bpd_checker (
   .clock          (clock),
   .reset          (reset),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_text_char  (rsp_text_char),
   .rsp_char_valid (rsp_char_valid),
   .rsp_last       (rsp_last)
);

[dv/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the tokenized basic detokenizer
// ---------------------------------------------------------------------------
// a short table of hand-picked program bytes runs first. the rows with
// obvious answers also carry the typed-in status and group size. random
// tokenized programs follow under several register settings and idling
// mixes. every response transfer is checked against an in-bench model of
// the line parser, in order.
module testbench;
   import bpd_pkg::*;

   localparam int CycleLimit = 400000;

   // one response transfer as seen on the rsp channel
   typedef struct packed {
      logic [7:0] chr;
      logic       cv;
      logic [2:0] st;
      logic       last;
   } text_out_type;

   // one directed stimulus row; chk marks rows whose answer is typed in
   typedef struct packed {
      logic [7:0] b;
      logic       beg;
      logic       chk;
      logic [2:0] st;
      logic [3:0] n;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_mem_byte;
   logic        req_begin_req;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [7:0]  rsp_text_char;
   logic        rsp_char_valid;
   logic [2:0]  rsp_status;
   logic        rsp_last;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [15:0] csr_wdata;

   basic_program_detokenizer_top dut (.*);

   // model state of the parser and its registers
   phase_type   m_phase;
   logic [15:0] m_addr;
   logic [15:0] m_line;
   logic [7:0]  m_left;
   logic [7:0]  m_pack [3];
   int          m_pcount;
   logic        m_str;
   logic        m_raw;
   logic [2:0]  m_status;
   logic [7:0]  m_page;
   logic [15:0] m_limit;

   logic [7:0]   line_text [$];
   text_out_type pending_text [$];

   int  mismatches;
   int  cycles;
   int  sent;
   int  gap_pct;
   int  stall_pct;

   stim_row_type plan [] ;

   // clock, 10 ns period
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // ---------------------------------------------------------------------
   // parser model
   // ---------------------------------------------------------------------
   function automatic void put_number(int unsigned v, int w);
      logic [7:0] dig [10];
      int k;
      k = 0;
      do begin
         dig[k] = 8'h30 + 8'(v % 10);
         v = v / 10;
         k++;
      end while (v != 0);
      for (int i = k; i < w; i++) line_text.push_back(CH_SPACE);
      while (k > 0) begin
         k--;
         line_text.push_back(dig[k]);
      end
   endfunction

   function automatic void close_line();
      line_text.push_back(CH_LF);
      m_phase = PH_CR;
      m_str = 1'b0;
      m_raw = 1'b0;
   endfunction

   function automatic void take_byte(logic [7:0] b);
      logic [16:0]    line_end;
      logic [63:0]    name;
      int unsigned    v;
      case (m_phase)
         PH_HI: begin
            if (b[7]) m_status = ST_END;
            else begin
               m_line = {b, 8'h00};
               m_phase = PH_LO;
            end
         end
         PH_LO: begin
            m_line = m_line | b;
            m_phase = PH_LEN;
         end
         PH_LEN: begin
            // address after the length byte wraps at 16 bits
            line_end = 17'(16'(m_addr + 16'd1)) + b;
            if (line_end >= m_limit) m_status = ST_PAST;
            else begin
               put_number(m_line, 5);
               m_left = b - 8'd4;
               m_phase = PH_BODY;
               if (m_left == 0) close_line();
            end
         end
         PH_BODY: begin
            m_left--;
            if (m_raw) line_text.push_back(b);
            else if (m_str) begin
               line_text.push_back(b);
               if (b == CH_QUOTE) m_str = 1'b0;
            end else if (b[7]) begin
               if (b == TOK_LINENO) begin
                  // packed line number needs three more bytes in this line
                  if (m_left < 3) begin
                     m_status = ST_OVERRUN;
                     return;
                  end
                  m_pcount = 0;
                  m_phase = PH_PACK;
                  return;
               end
               name = KW_NAME[b[6:0]];
               for (int i = NameBytes - 1; i >= 0; i--)
                  if (name[8*i +: 8] != 0) line_text.push_back(name[8*i +: 8]);
               if (b == TOK_DATA || b == TOK_REM) m_raw = 1'b1;
            end else begin
               line_text.push_back(b);
               if (b == CH_QUOTE) m_str = 1'b1;
            end
            if (m_left == 0) close_line();
         end
         PH_PACK: begin
            m_left--;
            m_pack[m_pcount] = b;
            m_pcount++;
            if (m_pcount == 3) begin
               v = {m_pack[1] & 8'h3f}
                 | ({m_pack[2] & 8'h3f} << 8)
                 | ({m_pack[0] & 8'h0c} << 12)
                 | ({m_pack[0] & 8'h30} << 2);
               v = (v ^ 32'h4040) & 32'hffff;
               put_number(v, 0);
               m_pcount = 0;
               m_phase = PH_BODY;
               if (m_left == 0) close_line();
            end
         end
         default: begin
            if (b != CH_CR) m_status = ST_NO_CR;
            else m_phase = PH_HI;
         end
      endcase
   endfunction

   function automatic void clear_parser();
      m_phase = PH_CR;
      m_line = '0;
      m_left = '0;
      m_pack = '{default: '0};
      m_pcount = 0;
      m_str = 1'b0;
      m_raw = 1'b0;
   endfunction

   // returns the size of the transfer group this byte causes
   function automatic int predict_text(logic [7:0] b, logic beg);
      line_text.delete();
      if (beg) begin
         clear_parser();
         m_status = ST_RUN;
         m_addr = {m_page, 8'h00};
         if (m_addr >= m_limit) m_status = ST_PAST;
      end
      if (m_status == ST_RUN) begin
         take_byte(b);
         m_addr = m_addr + 16'd1;
      end
      if (line_text.size() == 0) begin
         pending_text.push_back('{8'h00, 1'b0, m_status, 1'b1});
         return 1;
      end
      foreach (line_text[k])
         pending_text.push_back('{line_text[k], 1'b1, m_status,
                                  k == line_text.size() - 1});
      return line_text.size();
   endfunction

   // ---------------------------------------------------------------------
   // drivers
   // ---------------------------------------------------------------------
   task automatic send_byte(logic [7:0] b, logic beg, output int n);
      req_valid <= 1'b1;
      req_mem_byte <= b;
      req_begin_req <= beg;
      do @(posedge clock); while (req_stall);
      n = predict_text(b, beg);
      sent++;
      if ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic push(logic [7:0] b, logic beg);
      int n;
      send_byte(b, beg, n);
   endtask

   task automatic write_reg(logic idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == REG_PAGE_HIGH) m_page = data[7:0];
      else m_limit = data;
      @(posedge clock);
   endtask

   // let every expected transfer arrive, then idle for a margin
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_text.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // one body byte of a random line, tokens and strings favored
   task automatic body_byte(inout int left);
      int pick;
      pick = $urandom_range(99);
      if (pick < 25) push(8'($urandom_range(8'h20, 8'h7e)), 1'b0);
      else if (pick < 35) push(CH_QUOTE, 1'b0);
      else if (pick < 65) push(8'($urandom_range(8'h80, 8'hff)), 1'b0);
      else if (pick < 77) begin
         push(TOK_LINENO, 1'b0);
         left--;
         for (int i = 0; i < 3 && left > 0; i++) begin
            push(8'($urandom), 1'b0);
            left--;
         end
         return;
      end else if (pick < 85) push($urandom_range(1) ? TOK_REM : TOK_DATA, 1'b0);
      else push(8'($urandom), 1'b0);
      left--;
   endtask

   // random tokenized programs until the budget of bytes is used
   task automatic run_programs(int budget);
      int stop_at;
      int left;
      logic [7:0] len;
      stop_at = sent + budget;
      while (sent < stop_at) begin
         push(CH_CR, 1'b1);
         repeat ($urandom_range(1, 4)) begin
            if (sent >= stop_at) break;
            // occasional noise or a broken header
            if ($urandom_range(99) < 6) push(8'($urandom), 1'($urandom));
            push($urandom_range(99) < 95 ? CH_CR : 8'($urandom), 1'b0);
            if ($urandom_range(99) < 8) begin
               push(8'($urandom_range(8'h80, 8'hff)), 1'b0);
               break;
            end
            push(8'($urandom_range(0, 8'h7f)), 1'b0);
            push(8'($urandom), 1'b0);
            if ($urandom_range(99) < 5) len = 8'($urandom_range(0, 3));
            else len = 8'($urandom_range(4, 12));
            push(len, 1'b0);
            left = 8'(len - 8'd4);
            while (left > 0 && sent < stop_at) body_byte(left);
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // receiver stall and response check
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      text_out_type want;
      text_out_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_text_char, rsp_char_valid, rsp_status, rsp_last};
         if (pending_text.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected transfer: char %h valid %b status %0d last %b",
                        got.chr, got.cv, got.st, got.last);
         end else begin
            want = pending_text.pop_front();
            if (got != want) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp char %h valid %b status %0d last %b, got %h %b %0d %b",
                           want.chr, want.cv, want.st, want.last,
                           got.chr, got.cv, got.st, got.last);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CycleLimit) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      int n;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mem_byte = '0;
      req_begin_req = 1'b0;
      csr_valid = 1'b0;
      csr_index = REG_PAGE_HIGH;
      csr_wdata = '0;
      mismatches = 0;
      cycles = 0;
      sent = 0;
      gap_pct = 0;
      stall_pct = 0;
      m_page = 8'd14;
      m_limit = 16'd32764;
      m_addr = '0;
      m_status = ST_RUN;
      clear_parser();

      plan = '{
         // no begin after reset: line 10 from address zero, empty body
         '{8'h0d, 1'b0, 1'b1, ST_RUN, 4'd1},
         '{8'h00, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'h0a, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'h04, 1'b0, 1'b1, ST_RUN, 4'd6},
         // line 20 at page: packed number, string, rem, raw bytes
         '{8'h0d, 1'b1, 1'b1, ST_RUN, 4'd1},
         '{8'h00, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'h14, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'h0e, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'h8d, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'h54, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'h40, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'h40, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'h22, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'hf4, 1'b0, 1'b1, ST_RUN, 4'd1},
         '{8'h22, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'hf4, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'hff, 1'b0, 1'b1, ST_RUN, 4'd1},
         '{8'h0d, 1'b0, 1'b1, ST_RUN, 4'd2},
         // end marker, then a byte that is ignored
         '{8'h0d, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'h80, 1'b0, 1'b1, ST_END, 4'd1},
         '{8'h55, 1'b0, 1'b1, ST_END, 4'd1},
         // longest keyword, then a nameless token that ends the line
         '{8'h0d, 1'b1, 1'b0, ST_RUN, 4'd0},
         '{8'h00, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'h01, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'h06, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'he2, 1'b0, 1'b1, ST_RUN, 4'd8},
         '{8'hce, 1'b0, 1'b1, ST_RUN, 4'd1},
         // missing line start
         '{8'h41, 1'b0, 1'b1, ST_NO_CR, 4'd1},
         // packed number token with too few body bytes left
         '{8'h0d, 1'b1, 1'b0, ST_RUN, 4'd0},
         '{8'h00, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'h02, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'h05, 1'b0, 1'b0, ST_RUN, 4'd0},
         '{8'h8d, 1'b0, 1'b1, ST_OVERRUN, 4'd1}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[r]) begin
         send_byte(plan[r].b, plan[r].beg, n);
         if (plan[r].chk && (m_status != plan[r].st || n != plan[r].n)) begin
            mismatches++;
            if (mismatches <= 10)
               $display("row %0d: exp status %0d group %0d, model gives %0d %0d",
                        r, plan[r].st, plan[r].n, m_status, n);
         end
      end
      drain();

      // defaults, no idling
      run_programs(15);
      drain();

      // page 0, limit 0x8000; sender idles
      write_reg(REG_PAGE_HIGH, 16'h0000);
      write_reg(REG_RAM_LIMIT, 16'h8000);
      gap_pct = 70;
      run_programs(15);
      drain();

      // tight limit so lines run past ram; receiver stalls
      write_reg(REG_PAGE_HIGH, 16'h7f);
      write_reg(REG_RAM_LIMIT, 16'h7f30);
      gap_pct = 0;
      stall_pct = 70;
      run_programs(15);
      drain();

      // page at top, limit zero: every begin lands past ram; both idle
      write_reg(REG_PAGE_HIGH, 16'h00ff);
      write_reg(REG_RAM_LIMIT, 16'h0000);
      gap_pct = 35;
      stall_pct = 35;
      run_programs(5);
      drain();

      // short length wraps to a long body, no idling
      write_reg(REG_PAGE_HIGH, 16'h0010);
      write_reg(REG_RAM_LIMIT, 16'h8000);
      gap_pct = 0;
      stall_pct = 0;
      push(CH_CR, 1'b1);
      push(8'h7f, 1'b0);
      push(8'hff, 1'b0);
      push(8'h02, 1'b0);
      repeat (6) push(8'($urandom), 1'b0);
      drain();

      if (mismatches == 0) $display("status: pass");
      else $display("status: fail");
      $finish;
   end

endmodule
